// ----- sv/hpe_pkg.sv -----
// Shared types, constants and elaboration-time helpers for the Hamming encoder.
// No dependencies; used by every module of the encoder.
`timescale 1ns / 1ps
`default_nettype none

package hpe_pkg;

  localparam int CW_W  = 63;   // codeword width, position p at bit p-1
  localparam int LEN_W = 6;    // code length width
  localparam int CFG_W = 6;    // data_bits register width
  localparam int PAR_N = 6;    // parity bits the widest code can use

  localparam logic [CFG_W-1:0] DATA_BITS_RESET = 6'd57;

  // Message bits already scattered to their codeword positions, plus length.
  typedef struct packed {
    logic [CW_W-1:0]  data_pos;
    logic [LEN_W-1:0] code_len;
  } hpe_entry_t;

  // 1-based codeword position of message bit j (j-th non power of two).
  function automatic int data_pos_f(input int j);
    int k;
    int res;
    k   = 0;
    res = 0;
    for (int p = 1; p <= CW_W; p++) begin
      if ((p & (p - 1)) != 0) begin
        if (k == j) begin
          res = p;
        end
        k++;
      end
    end
    return res;
  endfunction

  // Positions covered by parity bit i: index has bit i set.
  function automatic logic [CW_W-1:0] parity_mask_f(input int i);
    logic [CW_W-1:0] mask;
    mask = '0;
    for (int p = 1; p <= CW_W; p++) begin
      mask[p-1] = ((p >> i) & 1) != 0;
    end
    return mask;
  endfunction

  // Least r with 2^r >= m + r + 1, for m from 1 to 57.
  function automatic logic [2:0] parity_count_f(input logic [CFG_W-1:0] m);
    logic [2:0] r;
    if (m <= 6'd1) begin
      r = 3'd2;
    end else if (m <= 6'd4) begin
      r = 3'd3;
    end else if (m <= 6'd11) begin
      r = 3'd4;
    end else if (m <= 6'd26) begin
      r = 3'd5;
    end else begin
      r = 3'd6;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- sv/hpe_front.sv -----
// Front end of the Hamming encoder: data_bits register, message masking and
// scatter to data positions, code length. Depends on hpe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hpe_front #(
  parameter int MAX_DATA_BITS = 57
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_valid_i,
  input  wire logic [hpe_pkg::CFG_W-1:0] cfg_data_i,
  input  wire logic [MAX_DATA_BITS-1:0] data_word_i,
  output hpe_pkg::hpe_entry_t           entry_o
);

  logic [hpe_pkg::CFG_W-1:0] data_bits_q;
  logic [hpe_pkg::CFG_W-1:0] data_bits_d;
  logic [hpe_pkg::CFG_W-1:0] eff_bits;
  logic [2:0]                par_cnt;
  logic [hpe_pkg::CW_W-1:0]  scattered;

  always_comb begin
    data_bits_d = cfg_valid_i ? cfg_data_i : data_bits_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_bits_q <= hpe_pkg::DATA_BITS_RESET;
    end else begin
      data_bits_q <= data_bits_d;
    end
  end

  // Clamp the message length into 1 .. MAX_DATA_BITS.
  always_comb begin
    if (data_bits_q == '0) begin
      eff_bits = 6'd1;
    end else if (data_bits_q > 6'(MAX_DATA_BITS)) begin
      eff_bits = 6'(MAX_DATA_BITS);
    end else begin
      eff_bits = data_bits_q;
    end
    par_cnt = hpe_pkg::parity_count_f(eff_bits);
  end

  // Drop message bits at and above the length, place the rest.
  always_comb begin
    scattered = '0;
    for (int j = 0; j < MAX_DATA_BITS; j++) begin
      scattered[hpe_pkg::data_pos_f(j)-1] = data_word_i[j] & (eff_bits > 6'(j));
    end
  end

  assign entry_o.data_pos = scattered;
  assign entry_o.code_len = eff_bits + {3'b000, par_cnt};

endmodule

`default_nettype wire

// ----- sv/hpe_queue.sv -----
// Two-entry queue between front and back of the Hamming encoder.
// Depends on hpe_pkg for the entry type.
`timescale 1ns / 1ps
`default_nettype none

module hpe_queue (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  hpe_pkg::hpe_entry_t push_entry_i,
  output logic              full_o,
  input  wire logic         pop_i,
  output logic              avail_o,
  output hpe_pkg::hpe_entry_t pop_entry_o
);

  localparam int Depth = 2;
  localparam int PtrW  = $clog2(Depth);

  hpe_pkg::hpe_entry_t   mem_q [Depth];
  logic [PtrW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [PtrW:0]         count_q, count_d;
  logic                  do_push;
  logic                  do_pop;

  assign full_o      = count_q == (PtrW + 1)'(Depth);
  assign avail_o     = count_q != '0;
  assign do_push     = push_i && !full_o;
  assign do_pop      = pop_i && avail_o;
  assign pop_entry_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q + (PtrW + 1)'(do_push) - (PtrW + 1)'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

`default_nettype wire

// ----- sv/hpe_back.sv -----
// Back end of the Hamming encoder: parity XOR trees and the output register.
// Depends on hpe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hpe_back (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      avail_i,
  input  hpe_pkg::hpe_entry_t            entry_i,
  output logic                           pop_o,
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output logic [hpe_pkg::CW_W-1:0]       codeword_o,
  output logic [hpe_pkg::LEN_W-1:0]      code_length_o
);

  logic                         out_valid_q, out_valid_d;
  logic [hpe_pkg::CW_W-1:0]     codeword_q, codeword_d;
  logic [hpe_pkg::LEN_W-1:0]    code_length_q, code_length_d;
  logic                         load;

  // Advance when the output register is empty or being taken.
  assign load  = !out_valid_q || !out_stall_i;
  assign pop_o = avail_i && load;

  always_comb begin
    codeword_d = entry_i.data_pos;
    for (int i = 0; i < hpe_pkg::PAR_N; i++) begin
      codeword_d[(1 << i) - 1] = ^(entry_i.data_pos & hpe_pkg::parity_mask_f(i));
    end
    code_length_d = entry_i.code_len;
    out_valid_d   = load ? avail_i : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      codeword_q    <= codeword_d;
      code_length_q <= code_length_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign codeword_o    = codeword_q;
  assign code_length_o = code_length_q;

endmodule

`default_nettype wire

// ----- sv/hamming_parity_encoder.sv -----
// Top level of the even-parity Hamming encoder: front, queue and back.
// Depends on hpe_pkg, hpe_front, hpe_queue and hpe_back.
//
//   channel   direction  handshake                payload
//   ------    ---------  -----------------------  ------------------------------
//   cfg       in         cfg_valid_i/cfg_ready_o  cfg_data_i (data_bits)
//   in        in         in_valid_i/in_stall_o    data_word_i
//   out       out        out_valid_o/out_stall_i  codeword_o, code_length_o
//
// One request per cycle sustained while out_stall_i stays low; a taken request
// is written into the queue, then loaded into the output register when it advances.
// The two-entry queue lets the front keep taking requests while a finished
// codeword waits on out_stall_i; in_stall_o rises only when the queue is full.
// Reset sets data_bits to 57 and empties queue and output register.
// cfg_ready_o is always high; write data_bits only while the encoder is idle.
`timescale 1ns / 1ps
`default_nettype none

module hamming_parity_encoder #(
  parameter int MAX_DATA_BITS = 57
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire logic [hpe_pkg::CFG_W-1:0]  cfg_data_i,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic [MAX_DATA_BITS-1:0]   data_word_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic [hpe_pkg::CW_W-1:0]        codeword_o,
  output logic [hpe_pkg::LEN_W-1:0]       code_length_o
);

  hpe_pkg::hpe_entry_t front_entry;
  hpe_pkg::hpe_entry_t back_entry;
  logic                q_full;
  logic                q_avail;
  logic                q_pop;

  // The register write port never holds off.
  assign cfg_ready_o = 1'b1;

  // Hold off new requests only when the queue has no room.
  assign in_stall_o = q_full;

  // Mask the message to data_bits, scatter it to data positions, size the code.
  hpe_front #(
    .MAX_DATA_BITS(MAX_DATA_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .data_word_i (data_word_i),
    .entry_o     (front_entry)
  );

  // Decouple request acceptance from result delivery.
  hpe_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (in_valid_i),
    .push_entry_i (front_entry),
    .full_o       (q_full),
    .pop_i        (q_pop),
    .avail_o      (q_avail),
    .pop_entry_o  (back_entry)
  );

  // Fill in parity positions and register the result.
  hpe_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .avail_i       (q_avail),
    .entry_i       (back_entry),
    .pop_o         (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .codeword_o    (codeword_o),
    .code_length_o (code_length_o)
  );

endmodule

`default_nettype wire
